// ===== src/csnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubed-sphere node position package
// Shared constants, register codes and types for the node position pipeline.
// ----------------------------------------------------------------------------
package csnp_pkg;

  // Fixed-point format and index range.
  localparam int FRAC_BITS         = 16;
  localparam int MAX_NODES_PER_DIM = 1024;
  localparam int IDX_W             = 10;
  localparam int Q24_SHIFT         = 24 - FRAC_BITS;

  // Pipeline depths of the iterative units.
  localparam int CORDIC_ITER = 28;
  localparam int ISQRT_STEPS = 32;
  localparam int DIV_STEPS   = 31;

  // Angle clamp at 89.99 degrees in Q.F.
  localparam longint ANGLE_LIMIT_L =
    (longint'(8999) * (longint'(1) << FRAC_BITS) + longint'(50)) / longint'(100);
  localparam logic signed [35:0] ANGLE_LIMIT = 36'(ANGLE_LIMIT_L);

  // sqrt(3) in Q30.
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

  // atan(2^-i) in degrees, Q24.
  localparam logic [29:0] ATAN_DEG_Q24 [CORDIC_ITER] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
    30'd29,        30'd14,        30'd7
  };

  // Configuration register codes.
  typedef enum logic [2:0] {
    REG_MIN_RADIUS   = 3'd0,
    REG_RADIAL_STEP  = 3'd1,
    REG_MIN_LON_DEG  = 3'd2,
    REG_LON_STEP_DEG = 3'd3,
    REG_MIN_LAT_DEG  = 3'd4,
    REG_LAT_STEP_DEG = 3'd5
  } cfg_reg_e;

  // Per-node data that rides beside the arithmetic units.
  typedef struct packed {
    logic             neg_l;
    logic             neg_b;
    logic             flag;
    logic [2:0]       ng;
    logic [41:0]      rs;
    logic [2:0][30:0] ms;
  } side_t;

  // Indices at or above the node count are taken as the last node.
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    if ({1'b0, v} >= (IDX_W+1)'(MAX_NODES_PER_DIM)) begin
      r = IDX_W'(MAX_NODES_PER_DIM - 1);
    end
    return r;
  endfunction

endpackage

// ===== src/csnp_cordic.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation lane
// One rotation step per register stage; gives cosine and sine of a degree angle.
// ----------------------------------------------------------------------------
module csnp_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [30:0]        angle_i,
  output logic               valid_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import csnp_pkg::*;

  logic signed [31:0] x_q [CORDIC_ITER];
  logic signed [31:0] y_q [CORDIC_ITER];
  logic signed [32:0] z_q [CORDIC_ITER];
  logic [CORDIC_ITER-1:0] v_q;

  logic signed [31:0] xi [CORDIC_ITER];
  logic signed [31:0] yi [CORDIC_ITER];
  logic signed [32:0] zi [CORDIC_ITER];
  logic signed [31:0] xd [CORDIC_ITER];
  logic signed [31:0] yd [CORDIC_ITER];
  logic signed [32:0] zd [CORDIC_ITER];

  // Rotate toward zero residual angle, one step per stage.
  always_comb begin
    for (int k = 0; k < CORDIC_ITER; k++) begin
      if (k == 0) begin
        xi[k] = 32'sd536870912;
        yi[k] = '0;
        zi[k] = $signed({2'b00, angle_i});
      end else begin
        xi[k] = x_q[k-1];
        yi[k] = y_q[k-1];
        zi[k] = z_q[k-1];
      end
      if (!zi[k][32]) begin
        xd[k] = xi[k] - (yi[k] >>> k);
        yd[k] = yi[k] + (xi[k] >>> k);
        zd[k] = zi[k] - $signed({3'b000, ATAN_DEG_Q24[k]});
      end else begin
        xd[k] = xi[k] + (yi[k] >>> k);
        yd[k] = yi[k] - (xi[k] >>> k);
        zd[k] = zi[k] + $signed({3'b000, ATAN_DEG_Q24[k]});
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[CORDIC_ITER-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CORDIC_ITER; k++) begin
        x_q[k] <= xd[k];
        y_q[k] <= yd[k];
        z_q[k] <= zd[k];
      end
    end
  end

  assign valid_o = v_q[CORDIC_ITER-1];
  assign cos_o   = x_q[CORDIC_ITER-1];
  assign sin_o   = y_q[CORDIC_ITER-1];

endmodule

// ===== src/csnp_isqrt.sv =====
// ----------------------------------------------------------------------------
// Integer square root pipeline
// Floor square root of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module csnp_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] value_i,
  output logic        valid_o,
  output logic [31:0] root_o
);
  import csnp_pkg::*;

  logic [63:0] v_q [ISQRT_STEPS];
  logic [63:0] r_q [ISQRT_STEPS];
  logic [ISQRT_STEPS-1:0] val_q;

  logic [63:0] vi [ISQRT_STEPS];
  logic [63:0] ri [ISQRT_STEPS];
  logic [63:0] vd [ISQRT_STEPS];
  logic [63:0] rd [ISQRT_STEPS];
  logic [64:0] trial [ISQRT_STEPS];

  // Digit recurrence: the test bit moves down two places per stage.
  always_comb begin
    for (int k = 0; k < ISQRT_STEPS; k++) begin
      if (k == 0) begin
        vi[k] = value_i;
        ri[k] = '0;
      end else begin
        vi[k] = v_q[k-1];
        ri[k] = r_q[k-1];
      end
      trial[k] = {1'b0, ri[k]} + (65'(1) << (62 - 2 * k));
      if ({1'b0, vi[k]} >= trial[k]) begin
        vd[k] = vi[k] - trial[k][63:0];
        rd[k] = (ri[k] >> 1) + (64'(1) << (62 - 2 * k));
      end else begin
        vd[k] = vi[k];
        rd[k] = ri[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= {val_q[ISQRT_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ISQRT_STEPS; k++) begin
        v_q[k] <= vd[k];
        r_q[k] <= rd[k];
      end
    end
  end

  assign valid_o = val_q[ISQRT_STEPS-1];
  assign root_o  = r_q[ISQRT_STEPS-1][31:0];

endmodule

// ===== src/csnp_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider pipeline
// Divides a 62-bit numerator by a 32-bit divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module csnp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [61:0] num_i,
  input  logic [31:0] den_i,
  output logic        valid_o,
  output logic [30:0] quot_o
);
  import csnp_pkg::*;

  logic [61:0] rem_q [DIV_STEPS];
  logic [31:0] den_q [DIV_STEPS];
  logic [30:0] quo_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] val_q;

  logic [61:0] remi [DIV_STEPS];
  logic [31:0] deni [DIV_STEPS];
  logic [30:0] quoi [DIV_STEPS];
  logic [61:0] remd [DIV_STEPS];
  logic [30:0] quod [DIV_STEPS];
  logic [63:0] trial [DIV_STEPS];

  // Quotient bits from the top down; the quotient is known to fit.
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        remi[k] = num_i;
        deni[k] = den_i;
        quoi[k] = '0;
      end else begin
        remi[k] = rem_q[k-1];
        deni[k] = den_q[k-1];
        quoi[k] = quo_q[k-1];
      end
      trial[k] = {32'b0, deni[k]} << (DIV_STEPS - 1 - k);
      if ({2'b00, remi[k]} >= trial[k]) begin
        remd[k] = remi[k] - trial[k][61:0];
        quod[k] = quoi[k] | (31'(1) << (DIV_STEPS - 1 - k));
      end else begin
        remd[k] = remi[k];
        quod[k] = quoi[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= {val_q[DIV_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k] <= remd[k];
        den_q[k] <= deni[k];
        quo_q[k] <= quod[k];
      end
    end
  end

  assign valid_o = val_q[DIV_STEPS-1];
  assign quot_o  = quo_q[DIV_STEPS-1];

endmodule

// ===== src/cubed_sphere_node_position.sv =====
// ----------------------------------------------------------------------------
// Cubed-sphere node position
// Gnomonic projection of a mesh node's grid indices onto one cubed-sphere cap.
// ----------------------------------------------------------------------------
// The block takes one node request per clock cycle while the output is not
// stalled, and passes it through the radius and angle registers, 28 CORDIC
// stages, the product and normalizing registers, 32 square-root stages, 31
// divider stages and the final scale and saturation registers. When the
// output request is not taken, the whole pipeline holds, so nothing is lost.
// Configuration writes take effect at once and should only be made while the
// pipeline is empty.
module cubed_sphere_node_position (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // Node request: radial_index [9:0], lon_index [19:10], lat_index [29:20].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Result: x_coord [31:0], y_coord [63:32], z_coord [95:64].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,
  // Result flag: saturated [0].
  output logic [0:0]  m_axis_tuser
);
  import csnp_pkg::*;

  typedef struct packed {
    logic        neg;
    logic        clamp;
    logic [30:0] ang;
  } angle_t;

  // Clamp the angle, split off its sign and move to degrees Q24.
  function automatic angle_t to_angle(input logic signed [35:0] deg);
    angle_t a;
    logic signed [35:0] d;
    logic [35:0] mag;
    d = deg;
    a.clamp = 1'b0;
    if (d > ANGLE_LIMIT) begin
      d = ANGLE_LIMIT;
      a.clamp = 1'b1;
    end
    if (d < -ANGLE_LIMIT) begin
      d = -ANGLE_LIMIT;
      a.clamp = 1'b1;
    end
    a.neg = d[35];
    mag = d[35] ? 36'(-d) : 36'(d);
    a.ang = 31'(mag << Q24_SHIFT);
    return a;
  endfunction

  logic en;

  // Configuration registers.
  logic [30:0]        min_radius_q, radial_step_q;
  logic signed [23:0] min_lon_q, min_lat_q;
  logic [23:0]        lon_step_q, lat_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_radius_q  <= 31'd65536;
      radial_step_q <= 31'd65536;
      min_lon_q     <= 24'shD30000;
      lon_step_q    <= 24'd65536;
      min_lat_q     <= 24'shD30000;
      lat_step_q    <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MIN_RADIUS:   min_radius_q  <= cfg_data_i;
        REG_RADIAL_STEP:  radial_step_q <= cfg_data_i;
        REG_MIN_LON_DEG:  min_lon_q     <= $signed(cfg_data_i[23:0]);
        REG_LON_STEP_DEG: lon_step_q    <= cfg_data_i[23:0];
        REG_MIN_LAT_DEG:  min_lat_q     <= $signed(cfg_data_i[23:0]);
        REG_LAT_STEP_DEG: lat_step_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a result.
  logic out_valid_q;
  assign en            = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: radius and angles, linear in the indices.
  logic [IDX_W-1:0]   ri, li, bi;
  logic [41:0]        radius_d, radius_q;
  logic signed [35:0] deg_l_d, deg_l_q, deg_b_d, deg_b_q;
  logic               v1_q;

  always_comb begin
    ri = clamp_idx(s_axis_tdata[9:0]);
    li = clamp_idx(s_axis_tdata[19:10]);
    bi = clamp_idx(s_axis_tdata[29:20]);
    radius_d = 42'(min_radius_q) + 42'(radial_step_q) * 42'(ri);
    deg_l_d  = 36'(min_lon_q) + $signed({2'b00, 34'(lon_step_q) * 34'(li)});
    deg_b_d  = 36'(min_lat_q) + $signed({2'b00, 34'(lat_step_q) * 34'(bi)});
  end

  // Stage 2: angle clamp and radius times sqrt(3) partial products.
  angle_t      al_d, ab_d;
  logic [30:0] ang_l_q, ang_b_q;
  logic        neg_l_q, neg_b_q, flag2_q, v2_q;
  logic [51:0] rs_lo_q, rs_hi_q;

  assign al_d = to_angle(deg_l_q);
  assign ab_d = to_angle(deg_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radius_q <= radius_d;
      deg_l_q  <= deg_l_d;
      deg_b_q  <= deg_b_d;
      ang_l_q  <= al_d.ang;
      ang_b_q  <= ab_d.ang;
      neg_l_q  <= al_d.neg;
      neg_b_q  <= ab_d.neg;
      flag2_q  <= al_d.clamp | ab_d.clamp;
      rs_lo_q  <= 52'(radius_q[20:0]) * 52'(SQRT3_Q30);
      rs_hi_q  <= 52'(radius_q[41:21]) * 52'(SQRT3_Q30);
    end
  end

  // Rounded scaled radius enters the side line beside the CORDIC lanes.
  logic [73:0] rs_sum;
  side_t       side_a_in;

  always_comb begin
    rs_sum = 74'(rs_lo_q) + (74'(rs_hi_q) << 21) + (74'(1) << 29);
    side_a_in       = '0;
    side_a_in.neg_l = neg_l_q;
    side_a_in.neg_b = neg_b_q;
    side_a_in.flag  = flag2_q;
    side_a_in.rs    = rs_sum[71:30];
  end

  // CORDIC lanes for longitude and latitude.
  logic               cv_l, cv_b;
  logic signed [31:0] c_l, s_l, c_b, s_b;

  csnp_cordic u_cordic_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .angle_i (ang_l_q),
    .valid_o (cv_l),
    .cos_o   (c_l),
    .sin_o   (s_l)
  );

  csnp_cordic u_cordic_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .angle_i (ang_b_q),
    .valid_o (cv_b),
    .cos_o   (c_b),
    .sin_o   (s_b)
  );

  side_t side_a_q [CORDIC_ITER];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q[0] <= side_a_in;
      for (int k = 1; k < CORDIC_ITER; k++) begin
        side_a_q[k] <= side_a_q[k-1];
      end
    end
  end

  // Stage 3: cosine floor, sine sign and the three components.
  logic signed [31:0] cl_f, cb_f, sl_f, sb_f;
  logic signed [63:0] p_d [3];
  logic signed [63:0] p_q [3];
  side_t              side3_q;
  logic               v3_q;

  always_comb begin
    cl_f = (c_l < 32'sd1) ? 32'sd1 : c_l;
    cb_f = (c_b < 32'sd1) ? 32'sd1 : c_b;
    sl_f = side_a_q[CORDIC_ITER-1].neg_l ? -s_l : s_l;
    sb_f = side_a_q[CORDIC_ITER-1].neg_b ? -s_b : s_b;
    p_d[0] = sl_f * cb_f;
    p_d[1] = sb_f * cl_f;
    p_d[2] = cl_f * cb_f;
  end

  // Stage 4: magnitudes and signs.
  logic [61:0] m4_q [3];
  side_t       side4_d, side4_q;
  logic        v4_q;

  always_comb begin
    side4_d = side3_q;
    for (int k = 0; k < 3; k++) begin
      side4_d.ng[k] = p_q[k][63];
    end
  end

  // Stage 5: shift that brings the largest magnitude below 2^31.
  logic [61:0] mx;
  logic [4:0]  sh_d, sh5_q;
  logic [61:0] m5_q [3];
  side_t       side5_q;
  logic        v5_q;

  always_comb begin
    mx = m4_q[0];
    if (m4_q[1] > mx) mx = m4_q[1];
    if (m4_q[2] > mx) mx = m4_q[2];
    sh_d = '0;
    for (int s = 31; s >= 0; s--) begin
      if ((mx >> s) < 62'(64'h80000000)) sh_d = 5'(s);
    end
  end

  // Stage 6: shifted magnitudes.
  side_t side6_d, side6_q;
  logic  v6_q;

  always_comb begin
    side6_d = side5_q;
    for (int k = 0; k < 3; k++) begin
      side6_d.ms[k] = 31'(m5_q[k] >> sh5_q);
    end
  end

  // Stage 7 and 8: squares and their sum.
  logic [61:0] sq7_q [3];
  side_t       side7_q, side8_q;
  logic [63:0] sum8_q;
  logic        v7_q, v8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v3_q <= cv_l & cv_b;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side_a_q[CORDIC_ITER-1];
      side4_q <= side4_d;
      side5_q <= side4_q;
      side6_q <= side6_d;
      side7_q <= side6_q;
      side8_q <= side7_q;
      sh5_q   <= sh_d;
      for (int k = 0; k < 3; k++) begin
        p_q[k]   <= p_d[k];
        m4_q[k]  <= p_q[k][63] ? 62'(-p_q[k]) : 62'(p_q[k]);
        m5_q[k]  <= m4_q[k];
        sq7_q[k] <= 62'(side6_q.ms[k]) * 62'(side6_q.ms[k]);
      end
      sum8_q <= 64'(sq7_q[0]) + 64'(sq7_q[1]) + 64'(sq7_q[2]);
    end
  end

  // Norm of the component vector.
  logic        nv;
  logic [31:0] norm;

  csnp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .value_i (sum8_q),
    .valid_o (nv),
    .root_o  (norm)
  );

  side_t side_b_q [ISQRT_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_b_q[0] <= side8_q;
      for (int k = 1; k < ISQRT_STEPS; k++) begin
        side_b_q[k] <= side_b_q[k-1];
      end
    end
  end

  // Unit components: rounded magnitude times 2^30 over the norm.
  logic [31:0] den;
  logic [61:0] num [3];
  logic [2:0]  dv;
  logic [30:0] u [3];

  always_comb begin
    den = (norm == 32'd0) ? 32'd1 : norm;
    for (int k = 0; k < 3; k++) begin
      num[k] = {side_b_q[ISQRT_STEPS-1].ms[k], 30'b0} + 62'(den >> 1);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    csnp_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (nv),
      .num_i   (num[g]),
      .den_i   (den),
      .valid_o (dv[g]),
      .quot_o  (u[g])
    );
  end

  side_t side_c_q [DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_c_q[0] <= side_b_q[ISQRT_STEPS-1];
      for (int k = 1; k < DIV_STEPS; k++) begin
        side_c_q[k] <= side_c_q[k-1];
      end
    end
  end

  // Stage 9: scaled radius times unit component, split in two products.
  logic [51:0] plo_q [3];
  logic [51:0] phi_q [3];
  side_t       side9_q;
  logic        v9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side9_q <= side_c_q[DIV_STEPS-1];
      for (int k = 0; k < 3; k++) begin
        plo_q[k] <= 52'(side_c_q[DIV_STEPS-1].rs[20:0]) * 52'(u[k]);
        phi_q[k] <= 52'(side_c_q[DIV_STEPS-1].rs[41:21]) * 52'(u[k]);
      end
    end
  end

  // Final stage: round, apply the sign and saturate.
  logic [73:0] psum [3];
  logic [43:0] mag [3];
  logic [31:0] coord_d [3];
  logic [2:0]  sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = 74'(plo_q[k]) + (74'(phi_q[k]) << 21) + (74'(1) << 29);
      mag[k]  = psum[k][73:30];
      sat[k]  = 1'b0;
      if (side9_q.ng[k]) begin
        if (mag[k] > 44'h80000000) begin
          coord_d[k] = 32'h80000000;
          sat[k] = 1'b1;
        end else begin
          coord_d[k] = 32'(44'd0 - mag[k]);
        end
      end else begin
        if (mag[k] > 44'h7FFFFFFF) begin
          coord_d[k] = 32'h7FFFFFFF;
          sat[k] = 1'b1;
        end else begin
          coord_d[k] = mag[k][31:0];
        end
      end
    end
  end

  logic [31:0] coord_q [3];
  logic        sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v9_q        <= &dv;
      out_valid_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        coord_q[k] <= coord_d[k];
      end
      sat_q <= side9_q.flag | (|sat);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {coord_q[2], coord_q[1], coord_q[0]};
  assign m_axis_tuser  = sat_q;

endmodule
